### hw/rtl/scsu_to_utf8_decoder_macros.svh
// Assertion macros used by the SCSU decoder checker.
// Depends on nothing; include by bare file name.
`ifndef SCSU_TO_UTF8_DECODER_MACROS_SVH
`define SCSU_TO_UTF8_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SCSU_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scsu assertion failed");

// Next-cycle implication, disabled during reset.
`define SCSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scsu assertion failed");

`endif

### hw/rtl/scsu_pkg.sv
// Shared types, constants and functions of the SCSU to UTF-8 decoder.
// No dependencies; used by scoped names in the top level, front end, queue and back end.
package scsu_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int CP_W        = 21;

  // Tag codes held while argument bytes are awaited.
  localparam logic [3:0] TAG_NONE   = 4'd0;
  localparam logic [3:0] TAG_UNIT   = 4'd1;
  localparam logic [3:0] TAG_EXT    = 4'd3;
  localparam logic [3:0] TAG_DEFWIN = 4'd8;  // 8..15 define window 0..7

  localparam logic [CP_W-1:0] CP_SPACE       = 21'h00020;
  localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h0FFFD;
  localparam logic [CP_W-1:0] CP_SUPP_BASE   = 21'h10000;

  typedef logic [CP_W-1:0] cp_t;

  // One queue entry: a code point to encode, or a truncated-tag error.
  typedef struct packed {
    logic err;
    cp_t  cp;
  } scsu_entry_t;

  typedef struct packed {
    logic        valid;
    scsu_entry_t entry;
  } scsu_push_t;

  localparam cp_t STATIC_WIN [8] = '{
    21'h00000, 21'h00080, 21'h00100, 21'h00300,
    21'h02000, 21'h02080, 21'h02100, 21'h03000
  };

  localparam cp_t INIT_WIN [8] = '{
    21'h00080, 21'h000C0, 21'h00400, 21'h00600,
    21'h00900, 21'h03040, 21'h030A0, 21'h0FF00
  };

  // Offset given by a window definition byte.
  function automatic cp_t window_base(input logic [7:0] x);
    cp_t r;
    r = '0;
    if (x >= 8'h01 && x < 8'h68) begin
      r = {6'b0, x, 7'b0};
    end else if (x >= 8'h68 && x < 8'hA8) begin
      r = {6'b0, x, 7'b0} + 21'h0AC00;
    end else begin
      case (x)
        8'hF9:   r = 21'h000C0;
        8'hFA:   r = 21'h00250;
        8'hFB:   r = 21'h00370;
        8'hFC:   r = 21'h00530;
        8'hFD:   r = 21'h03040;
        8'hFE:   r = 21'h030A0;
        8'hFF:   r = 21'h0FF60;
        default: r = '0;
      endcase
    end
    return r;
  endfunction

  // UTF-8 sequence length minus one.
  function automatic logic [1:0] utf8_len_m1(input cp_t cp);
    logic [1:0] r;
    if (cp < 21'h80)          r = 2'd0;
    else if (cp < 21'h800)    r = 2'd1;
    else if (cp < 21'h10000)  r = 2'd2;
    else                      r = 2'd3;
    return r;
  endfunction

  // Byte number pos of the UTF-8 sequence for cp.
  function automatic logic [7:0] utf8_byte(input cp_t cp, input logic [1:0] len_m1,
                                           input logic [1:0] pos);
    logic [7:0] r;
    r = '0;
    case (len_m1)
      2'd0: r = {1'b0, cp[6:0]};
      2'd1: begin
        case (pos)
          2'd0:    r = {3'b110, cp[10:6]};
          default: r = {2'b10, cp[5:0]};
        endcase
      end
      2'd2: begin
        case (pos)
          2'd0:    r = {4'b1110, cp[15:12]};
          2'd1:    r = {2'b10, cp[11:6]};
          default: r = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        case (pos)
          2'd0:    r = {5'b11110, cp[20:18]};
          2'd1:    r = {2'b10, cp[17:12]};
          2'd2:    r = {2'b10, cp[11:6]};
          default: r = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/scsu_to_utf8_decoder.sv
// Top level of the SCSU to UTF-8 decoder: front end, entry queue, back end.
// Depends on scsu_pkg, scsu_front, scsu_queue and scsu_back.
//
//   channel  handshake             payload
//   in       in_valid / in_ready   in_byte[7:0], last_byte
//   out      out_valid / out_ready out_byte[7:0], char_last, status
//
// One SCSU byte is accepted per cycle while the queue has room; the front end
// resolves it to a code point (or nothing) in that same cycle.
// The back end sends one UTF-8 byte per cycle unless out_ready stalls it, so a code
// point takes one to four output bytes; its single output port sets the drain rate.
// A first output byte passes through a queue slot and then the output register.
// Reset (rst, synchronous) restores the initial windows and empties the queue;
// a byte with last_byte set returns the front end to the same state.
// A stalled output fills the queue; in_ready drops only when it is full.
module scsu_to_utf8_decoder #(
  parameter int QUEUE_DEPTH = scsu_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       char_last,
  output logic       status
);

  scsu_pkg::scsu_push_t  push;
  scsu_pkg::scsu_entry_t head;
  logic q_empty;
  logic q_full;
  logic pop;
  logic accept;

  // Hold input while the queue cannot take a worst-case entry.
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  scsu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (in_byte),
    .last_byte (last_byte),
    .push      (push)
  );

  scsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .empty (q_empty),
    .full  (q_full)
  );

  // Drain entries one UTF-8 byte at a time.
  scsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (!q_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .char_last  (char_last),
    .status     (status)
  );

endmodule

### hw/rtl/scsu_front.sv
// Front end: accepts SCSU bytes, tracks mode, windows, tags and surrogates,
// and pushes resolved code points or errors. Depends on scsu_pkg.
module scsu_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           in_byte,
  input  logic                 last_byte,
  output scsu_pkg::scsu_push_t push
);

  scsu_pkg::cp_t win [8];
  logic       unicode_mode, unicode_mode_next;
  logic [2:0] live_window, live_window_next;
  logic [3:0] quote_window, quote_window_next;
  logic [3:0] pending_tag, pending_tag_next;
  logic [1:0] args_remaining, args_remaining_next;
  logic [7:0] first_arg, first_arg_next;
  logic [9:0] lead_unit, lead_unit_next;
  logic       surrogate_valid, surrogate_valid_next;

  logic          win_we;
  logic [2:0]    win_wa;
  scsu_pkg::cp_t win_wd;
  logic [2:0]    win_ra;
  scsu_pkg::cp_t win_rd;
  logic          deliver;
  scsu_pkg::cp_t cp_raw;
  scsu_pkg::cp_t cp_out;
  logic          emit;
  logic          err;

  assign win_ra = (quote_window != 4'd0) ? (quote_window[2:0] - 3'd1) : live_window;
  assign win_rd = win[win_ra];

  always_comb begin
    unicode_mode_next    = unicode_mode;
    live_window_next     = live_window;
    quote_window_next    = quote_window;
    pending_tag_next     = pending_tag;
    args_remaining_next  = args_remaining;
    first_arg_next       = first_arg;
    lead_unit_next       = lead_unit;
    surrogate_valid_next = surrogate_valid;
    win_we  = 1'b0;
    win_wa  = '0;
    win_wd  = '0;
    deliver = 1'b0;
    cp_raw  = '0;
    cp_out  = '0;
    emit    = 1'b0;
    err     = 1'b0;

    if (pending_tag != scsu_pkg::TAG_NONE) begin
      if (args_remaining == 2'd2) begin
        first_arg_next      = in_byte;
        args_remaining_next = 2'd1;
      end else begin
        pending_tag_next    = scsu_pkg::TAG_NONE;
        args_remaining_next = 2'd0;
        if (pending_tag == scsu_pkg::TAG_UNIT) begin
          deliver = 1'b1;
          cp_raw  = {5'b0, first_arg, in_byte};
        end else if (pending_tag == scsu_pkg::TAG_EXT) begin
          win_we = 1'b1;
          win_wa = first_arg[7:5];
          win_wd = scsu_pkg::CP_SUPP_BASE + {1'b0, first_arg[4:0], in_byte, 7'b0};
          live_window_next  = first_arg[7:5];
          unicode_mode_next = 1'b0;
        end else begin
          win_we = 1'b1;
          win_wa = pending_tag[2:0];
          win_wd = scsu_pkg::window_base(in_byte);
          live_window_next  = pending_tag[2:0];
          unicode_mode_next = 1'b0;
        end
      end
    end else if (quote_window != 4'd0) begin
      deliver = 1'b1;
      quote_window_next = 4'd0;
      if (!in_byte[7]) begin
        cp_raw = scsu_pkg::STATIC_WIN[win_ra] + {13'b0, in_byte};
      end else begin
        cp_raw = win_rd + {14'b0, in_byte[6:0]};
      end
    end else if (unicode_mode) begin
      if (in_byte >= 8'hE0 && in_byte <= 8'hE7) begin
        live_window_next  = in_byte[2:0];
        unicode_mode_next = 1'b0;
      end else if (in_byte >= 8'hE8 && in_byte <= 8'hEF) begin
        pending_tag_next    = scsu_pkg::TAG_DEFWIN | {1'b0, in_byte[2:0]};
        args_remaining_next = 2'd1;
      end else if (in_byte == 8'hF0) begin
        pending_tag_next    = scsu_pkg::TAG_UNIT;
        args_remaining_next = 2'd2;
      end else if (in_byte == 8'hF1) begin
        pending_tag_next    = scsu_pkg::TAG_EXT;
        args_remaining_next = 2'd2;
      end else begin
        first_arg_next      = in_byte;
        pending_tag_next    = scsu_pkg::TAG_UNIT;
        args_remaining_next = 2'd1;
      end
    end else begin
      if (in_byte == 8'h0F) begin
        unicode_mode_next = 1'b1;
      end else if (in_byte == 8'h0E) begin
        pending_tag_next    = scsu_pkg::TAG_UNIT;
        args_remaining_next = 2'd2;
      end else if (in_byte >= 8'h01 && in_byte <= 8'h08) begin
        quote_window_next = in_byte[3:0];
      end else if (in_byte >= 8'h10 && in_byte <= 8'h17) begin
        live_window_next = in_byte[2:0];
      end else if (in_byte >= 8'h18 && in_byte <= 8'h1F) begin
        pending_tag_next    = scsu_pkg::TAG_DEFWIN | {1'b0, in_byte[2:0]};
        args_remaining_next = 2'd1;
      end else if (in_byte == 8'h0B) begin
        pending_tag_next    = scsu_pkg::TAG_EXT;
        args_remaining_next = 2'd2;
      end else if (in_byte == 8'h09 || in_byte == 8'h0A || in_byte == 8'h0D) begin
        deliver = 1'b1;
        cp_raw  = scsu_pkg::CP_SPACE;
      end else if (in_byte >= 8'h20 && in_byte <= 8'h7F) begin
        deliver = 1'b1;
        cp_raw  = {13'b0, in_byte};
      end else if (in_byte[7]) begin
        deliver = 1'b1;
        cp_raw  = win_rd + {14'b0, in_byte[6:0]};
      end else begin
        deliver = 1'b1;
        cp_raw  = scsu_pkg::CP_REPLACEMENT;
      end
    end

    // Resolve surrogates: hold a high half, pair or replace a low half.
    if (deliver) begin
      if (cp_raw >= 21'h0D800 && cp_raw <= 21'h0DBFF) begin
        lead_unit_next       = cp_raw[9:0];
        surrogate_valid_next = 1'b1;
      end else begin
        cp_out = cp_raw;
        if (cp_raw >= 21'h0DC00 && cp_raw <= 21'h0DFFF) begin
          cp_out = surrogate_valid
                 ? scsu_pkg::CP_SUPP_BASE + {1'b0, lead_unit, cp_raw[9:0]}
                 : scsu_pkg::CP_REPLACEMENT;
        end
        lead_unit_next       = '0;
        surrogate_valid_next = 1'b0;
        emit = (cp_out != '0);
      end
    end

    if (last_byte && pending_tag_next != scsu_pkg::TAG_NONE) begin
      emit   = 1'b1;
      err    = 1'b1;
      cp_out = '0;
    end
  end

  assign push.valid     = accept & emit;
  assign push.entry.err = err;
  assign push.entry.cp  = cp_out;

  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      unicode_mode    <= 1'b0;
      live_window     <= '0;
      quote_window    <= '0;
      pending_tag     <= scsu_pkg::TAG_NONE;
      args_remaining  <= '0;
      first_arg       <= '0;
      lead_unit       <= '0;
      surrogate_valid <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        win[i] <= scsu_pkg::INIT_WIN[i];
      end
    end else if (accept) begin
      unicode_mode    <= unicode_mode_next;
      live_window     <= live_window_next;
      quote_window    <= quote_window_next;
      pending_tag     <= pending_tag_next;
      args_remaining  <= args_remaining_next;
      first_arg       <= first_arg_next;
      lead_unit       <= lead_unit_next;
      surrogate_valid <= surrogate_valid_next;
      if (win_we) begin
        win[win_wa] <= win_wd;
      end
    end
  end

endmodule

### hw/rtl/scsu_queue.sv
// Short queue of code point entries between front and back end.
// Depends on scsu_pkg for the entry type.
module scsu_queue #(
  parameter int DEPTH = scsu_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  scsu_pkg::scsu_push_t  push,
  input  logic                  pop,
  output scsu_pkg::scsu_entry_t head,
  output logic                  empty,
  output logic                  full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  scsu_pkg::scsu_entry_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic do_push;
  logic do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CNT_FULL);
  assign do_push = push.valid && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hw/rtl/scsu_back.sv
// Back end: expands each queued code point into UTF-8 bytes through an
// output register. Depends on scsu_pkg for the entry type and encoder.
module scsu_back (
  input  logic                  clk,
  input  logic                  rst,
  input  scsu_pkg::scsu_entry_t head,
  input  logic                  head_valid,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  char_last,
  output logic                  status
);

  logic [1:0] pos;
  logic [1:0] len_m1;
  logic       load;
  logic       final_byte;
  logic [7:0] byte_val;

  assign len_m1     = head.err ? 2'd0 : scsu_pkg::utf8_len_m1(head.cp);
  assign final_byte = (pos == len_m1);
  assign byte_val   = head.err ? 8'h00 : scsu_pkg::utf8_byte(head.cp, len_m1, pos);
  assign load       = head_valid && (!out_valid || out_ready);
  assign pop        = load && final_byte;

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte  <= byte_val;
      char_last <= final_byte;
      status    <= head.err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        pos       <= final_byte ? 2'd0 : pos + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/scsu_checker.sv
// Port-level checks of the SCSU to UTF-8 decoder, bound to the top level.
// Depends on scsu_to_utf8_decoder_macros.svh.
`include "scsu_to_utf8_decoder_macros.svh"

module scsu_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       char_last,
  input logic       status
);

  // Hold a stalled output item.
  `SCSU_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(char_last) && $stable(status))

  // An error item is a single zero byte that closes its character.
  `SCSU_ASSERT_NOW(a_err_form, clk, rst, out_valid && status, char_last && out_byte == 8'h00)

  // A byte that does not close a character is a lead or continuation byte.
  `SCSU_ASSERT_NOW(a_multi_high, clk, rst, out_valid && !char_last, out_byte[7] && !status)

  // After a non-final byte is taken, the next item is a continuation byte.
  `SCSU_ASSERT_NEXT(a_cont_follow, clk, rst, out_valid && out_ready && !char_last, !out_valid || (out_byte[7:6] == 2'b10 && !status))

endmodule

bind scsu_to_utf8_decoder scsu_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_byte  (out_byte),
  .char_last (char_last),
  .status    (status)
);
